// ===== design/phase_to_delay_count_top_assert.svh =====
// Assertion macros for the phase to delay count block.
// Used by the port checker; needs clk and rst in the enclosing scope.
`ifndef PHASE_TO_DELAY_COUNT_TOP_ASSERT_SVH
`define PHASE_TO_DELAY_COUNT_TOP_ASSERT_SVH

// checked outside reset
`define PTDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset too
`define PTDC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ptdc_pkg.sv =====
// Shared types and constants of the phase to delay count block.
// No dependencies.
`default_nettype none
package ptdc_pkg;

  localparam int SUM_W       = 32;
  localparam int FIELD_W     = 24;
  localparam int XY_W        = 51;
  localparam int Z_W         = 34;
  localparam int PRESCALE_SH = 16;
  localparam int ATAN_LEN    = 24;

  localparam logic signed [SUM_W-1:0] SUM_OFFSET = 32'sd4;
  localparam logic signed [Z_W-1:0]   Z_QUARTER  = 34'sh0_4000_0000;
  localparam logic signed [Z_W-1:0]   Z_HALF     = 34'sh0_8000_0000;

  localparam logic [31:0] ATAN_TURN32 [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   hold;
    logic [FIELD_W-1:0]     period;
    logic [FIELD_W-1:0]     manual;
  } ptdc_vec_t;

endpackage
`default_nettype wire

// ===== design/ptdc_front.sv =====
// Input stage: offset and saturate the sums, prescale, fold into the right half plane.
// Depends on ptdc_pkg.
`default_nettype none
module ptdc_front import ptdc_pkg::*; #(
  parameter int PERIOD_BITS = 24
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [FIELD_W-1:0]      period_ticks,
  input  wire logic signed [SUM_W-1:0] sine_sum,
  input  wire logic signed [SUM_W-1:0] cosine_sum,
  input  wire logic [FIELD_W-1:0]      manual_shift,
  output logic                         dn_valid,
  input  wire logic                    dn_ready,
  output ptdc_vec_t                    dn_data
);

  localparam logic [FIELD_W-1:0] PERIOD_MASK =
    (PERIOD_BITS >= FIELD_W) ? {FIELD_W{1'b1}} : FIELD_W'((64'd1 << PERIOD_BITS) - 64'd1);
  localparam logic signed [SUM_W:0] SUM_MAX = 33'sh0_7FFF_FFFF;

  logic signed [SUM_W:0]   s_wide;
  logic signed [SUM_W:0]   c_wide;
  logic signed [SUM_W-1:0] s;
  logic signed [SUM_W-1:0] c;
  logic signed [XY_W-1:0]  sx;
  logic signed [XY_W-1:0]  sy;
  ptdc_vec_t               vec_next;

  always_comb begin
    s_wide = {sine_sum[SUM_W-1], sine_sum} + {SUM_OFFSET[SUM_W-1], SUM_OFFSET};
    c_wide = {cosine_sum[SUM_W-1], cosine_sum} + {SUM_OFFSET[SUM_W-1], SUM_OFFSET};
    s = (s_wide > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : s_wide[SUM_W-1:0];
    c = (c_wide > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : c_wide[SUM_W-1:0];
    sx = {{(XY_W-SUM_W){c[SUM_W-1]}}, c} <<< PRESCALE_SH;
    sy = {{(XY_W-SUM_W){s[SUM_W-1]}}, s} <<< PRESCALE_SH;

    vec_next.x      = sx;
    vec_next.y      = sy;
    vec_next.z      = '0;
    vec_next.hold   = 1'b0;
    vec_next.period = period_ticks & PERIOD_MASK;
    vec_next.manual = manual_shift & PERIOD_MASK;
    if (s == '0) begin
      vec_next.hold = 1'b1;
      vec_next.z    = (c < 0) ? Z_HALF : '0;
    end else if (c == '0) begin
      vec_next.hold = 1'b1;
      vec_next.z    = (s > 0) ? Z_QUARTER : -Z_QUARTER;
    end else if (c < 0) begin
      if (s > 0) begin
        vec_next.x = sy;
        vec_next.y = -sx;
        vec_next.z = Z_QUARTER;
      end else begin
        vec_next.x = -sy;
        vec_next.y = sx;
        vec_next.z = -Z_QUARTER;
      end
    end
  end

  assign in_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (in_ready) begin
      dn_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      dn_data <= vec_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/ptdc_cell.sv =====
// One CORDIC vectoring cell: a shift-add micro-rotation toward the x axis, skipped for held vectors.
// Depends on ptdc_pkg for the vector type and the arctangent table.
`default_nettype none
module ptdc_cell import ptdc_pkg::*; #(
  parameter int STAGE = 0
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      up_valid,
  output logic           up_ready,
  input  wire ptdc_vec_t up_data,
  output logic           dn_valid,
  input  wire logic      dn_ready,
  output ptdc_vec_t      dn_data
);

  logic signed [XY_W-1:0] x;
  logic signed [XY_W-1:0] y;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic signed [Z_W-1:0]  z;
  logic signed [Z_W-1:0]  step;
  ptdc_vec_t              vec_next;

  always_comb begin
    x        = up_data.x;
    y        = up_data.y;
    z        = up_data.z;
    xs       = x >>> STAGE;
    ys       = y >>> STAGE;
    step     = signed'({2'b00, ATAN_TURN32[STAGE]});
    vec_next = up_data;
    if (!up_data.hold) begin
      if (y > 0) begin
        vec_next.x = x + ys;
        vec_next.y = y - xs;
        vec_next.z = z + step;
      end else begin
        vec_next.x = x - ys;
        vec_next.y = y + xs;
        vec_next.z = z - step;
      end
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_valid && up_ready) begin
      dn_data <= vec_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/ptdc_back.sv =====
// Output stages: round the angle to a turn fraction, wrap and clamp, then scale by period
// in auto mode or pass the manual shift in manual mode. Depends on ptdc_pkg.
`default_nettype none
module ptdc_back import ptdc_pkg::*; #(
  parameter int PHASE_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                auto_mode,
  input  wire logic                up_valid,
  output logic                     up_ready,
  input  wire ptdc_vec_t           up_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [PHASE_BITS:0]      phase_turn,
  output logic [FIELD_W-1:0]       shift_count
);

  localparam logic signed [Z_W-1:0] ROUND_HALF =
    signed'(Z_W'(1) << (31 - PHASE_BITS));
  localparam logic signed [PHASE_BITS+1:0] FULL =
    signed'((PHASE_BITS+2)'(1) << PHASE_BITS);
  localparam logic signed [PHASE_BITS+1:0] ONE = signed'((PHASE_BITS+2)'(1));

  logic signed [Z_W-1:0]          z_round;
  logic signed [PHASE_BITS+1:0]   p_raw;
  logic signed [PHASE_BITS+1:0]   p_wrap;
  logic [PHASE_BITS:0]            p_next;
  logic                           a_valid;
  logic                           a_ready;
  logic [PHASE_BITS:0]            a_phase;
  logic [FIELD_W-1:0]             a_period;
  logic [FIELD_W-1:0]             a_manual;
  logic [PHASE_BITS+FIELD_W:0]    product;

  always_comb begin
    z_round = up_data.z + ROUND_HALF;
    p_raw   = (PHASE_BITS+2)'(z_round >>> (32 - PHASE_BITS));
    p_wrap  = (p_raw <= 0) ? p_raw + FULL : p_raw;
    if (p_wrap > FULL) begin
      p_wrap = FULL;
    end else if (p_wrap < ONE) begin
      p_wrap = ONE;
    end
    p_next = p_wrap[PHASE_BITS:0];
  end

  assign up_ready = !a_valid || a_ready;
  assign a_ready  = !out_valid || out_ready;
  assign product  = {{FIELD_W{1'b0}}, a_phase} * {{(PHASE_BITS+1){1'b0}}, a_period};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (up_ready) begin
        a_valid <= up_valid;
      end
      if (a_ready) begin
        out_valid <= a_valid;
      end
    end
    if (up_valid && up_ready) begin
      a_phase  <= p_next;
      a_period <= up_data.period;
      a_manual <= up_data.manual;
    end
    if (a_valid && a_ready) begin
      phase_turn  <= a_phase;
      shift_count <= auto_mode ? product[PHASE_BITS+FIELD_W-1:PHASE_BITS] : a_manual;
    end
  end

endmodule
`default_nettype wire

// ===== design/phase_to_delay_count_top.sv =====
// Top level of the phase to delay count block: input stage, CORDIC cell row, output stages.
// Depends on ptdc_pkg, ptdc_front, ptdc_cell and ptdc_back.
//
// Takes one measurement per clock and returns one result per clock when out_ready stays
// high. Each item passes one input register, CORDIC_STAGES vectoring cells, one
// rounding register and one multiplier register on its way to the output. Every stage
// holds its own valid bit; a stall at the output fills empty stages first and reaches
// in_ready only once the whole row is occupied.
// Write auto_mode only while no item is in flight.
`default_nettype none
module phase_to_delay_count_top import ptdc_pkg::*; #(
  parameter int PHASE_BITS    = 16,
  parameter int CORDIC_STAGES = 16,
  parameter int PERIOD_BITS   = 24
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_wr_en,
  input  wire logic                    cfg_wr_data,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [FIELD_W-1:0]      period_ticks,
  input  wire logic signed [SUM_W-1:0] sine_sum,
  input  wire logic signed [SUM_W-1:0] cosine_sum,
  input  wire logic [FIELD_W-1:0]      manual_shift,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [PHASE_BITS:0]          phase_turn,
  output logic [FIELD_W-1:0]           shift_count
);

  logic      auto_mode;
  logic      row_valid [CORDIC_STAGES+1];
  logic      row_ready [CORDIC_STAGES+1];
  ptdc_vec_t row_data  [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_mode <= 1'b1;
    end else if (cfg_wr_en) begin
      auto_mode <= cfg_wr_data;
    end
  end

  ptdc_front #(
    .PERIOD_BITS (PERIOD_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .period_ticks (period_ticks),
    .sine_sum     (sine_sum),
    .cosine_sum   (cosine_sum),
    .manual_shift (manual_shift),
    .dn_valid     (row_valid[0]),
    .dn_ready     (row_ready[0]),
    .dn_data      (row_data[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    ptdc_cell #(
      .STAGE (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (row_valid[i]),
      .up_ready (row_ready[i]),
      .up_data  (row_data[i]),
      .dn_valid (row_valid[i+1]),
      .dn_ready (row_ready[i+1]),
      .dn_data  (row_data[i+1])
    );
  end

  ptdc_back #(
    .PHASE_BITS (PHASE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .auto_mode   (auto_mode),
    .up_valid    (row_valid[CORDIC_STAGES]),
    .up_ready    (row_ready[CORDIC_STAGES]),
    .up_data     (row_data[CORDIC_STAGES]),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .phase_turn  (phase_turn),
    .shift_count (shift_count)
  );

endmodule
`default_nettype wire

// ===== design/ptdc_checker.sv =====
// Port checker for the phase to delay count block, bound to its top level.
// Depends on ptdc_pkg and phase_to_delay_count_top_assert.svh.
`default_nettype none
`include "phase_to_delay_count_top_assert.svh"
module ptdc_checker import ptdc_pkg::*; #(
  parameter int PHASE_BITS = 16
) (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [PHASE_BITS:0] phase_turn,
  input wire logic [FIELD_W-1:0]  shift_count
);

  localparam logic [PHASE_BITS:0] FULL = (PHASE_BITS+1)'(1) << PHASE_BITS;

  `PTDC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(phase_turn) && $stable(shift_count), "result changed before transfer")
  `PTDC_ASSERT(a_phase_range, out_valid |-> phase_turn != '0 && phase_turn <= FULL, "phase outside one turn")
  `PTDC_ASSERT_RST(a_reset_empty, rst |=> !out_valid && in_ready, "pipeline not empty after reset")

endmodule

bind phase_to_delay_count_top ptdc_checker #(
  .PHASE_BITS (PHASE_BITS)
) u_ptdc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .phase_turn  (phase_turn),
  .shift_count (shift_count)
);
`default_nettype wire

// ===== tb/phase_to_delay_count_checker.sv =====
`timescale 1ns / 100ps
// Result checker for phase_to_delay_count_top: predicts phase and delay count per transfer.
// Depends on ptdc_pkg for field widths, the angle table and the turn constants.
module phase_to_delay_count_checker
  import ptdc_pkg::*;
#(
  parameter int PHASE_BITS    = 16,
  parameter int CORDIC_STAGES = 16,
  parameter int PERIOD_BITS   = 24
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic                    cfg_wr_data,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [FIELD_W-1:0]      period_ticks,
  input  logic signed [SUM_W-1:0] sine_sum,
  input  logic signed [SUM_W-1:0] cosine_sum,
  input  logic [FIELD_W-1:0]      manual_shift,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [PHASE_BITS:0]     phase_turn,
  input  logic [FIELD_W-1:0]      shift_count,
  output int                      fail_count,
  output int                      pending_count
);

  typedef struct {
    logic [PHASE_BITS:0] phase;
    logic [FIELD_W-1:0]  shift;
  } delay_result_t;

  localparam longint FULL_TURN   = longint'(1) <<< PHASE_BITS;
  localparam longint PERIOD_MASK = (longint'(1) <<< PERIOD_BITS) - 1;
  localparam longint SUM_LIMIT   = 64'sd2147483647;

  delay_result_t expected_results[$];
  logic          auto_on;

  function automatic longint offset_sum(logic signed [SUM_W-1:0] raw);
    longint v;
    v = longint'(raw) + longint'(SUM_OFFSET);
    if (v > SUM_LIMIT) v = SUM_LIMIT;
    return v;
  endfunction

  function automatic delay_result_t predict_delay(logic [FIELD_W-1:0] period,
                                                  logic signed [SUM_W-1:0] s_raw,
                                                  logic signed [SUM_W-1:0] c_raw,
                                                  logic [FIELD_W-1:0] manual,
                                                  logic mode_auto);
    longint s, c, x, y, z, xs, ys, t, p, per, shift;
    delay_result_t r;
    s = offset_sum(s_raw);
    c = offset_sum(c_raw);
    per = longint'(period) & PERIOD_MASK;
    if (s == 0) begin
      z = (c < 0) ? longint'(Z_HALF) : 0;
    end else if (c == 0) begin
      z = (s > 0) ? longint'(Z_QUARTER) : -longint'(Z_QUARTER);
    end else begin
      x = c <<< PRESCALE_SH;
      y = s <<< PRESCALE_SH;
      z = 0;
      // rotate into the right half plane
      if (x < 0) begin
        t = x;
        if (y > 0) begin
          x = y;
          y = -t;
          z = longint'(Z_QUARTER);
        end else begin
          x = -y;
          y = t;
          z = -longint'(Z_QUARTER);
        end
      end
      for (int i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          z = z + longint'(ATAN_TURN32[i]);
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - longint'(ATAN_TURN32[i]);
        end
      end
    end
    p = (z + (longint'(1) <<< (31 - PHASE_BITS))) >>> (32 - PHASE_BITS);
    if (p <= 0) p = p + FULL_TURN;
    if (p > FULL_TURN) p = FULL_TURN;
    if (p < 1) p = 1;
    if (mode_auto) shift = ((p * per) >>> PHASE_BITS) & PERIOD_MASK;
    else shift = longint'(manual) & PERIOD_MASK;
    r.phase = p[PHASE_BITS:0];
    r.shift = shift[FIELD_W-1:0];
    return r;
  endfunction

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    delay_result_t want;
    if (rst) begin
      auto_on <= 1'b1;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no pending measurement: phase_turn %0d shift_count %0d",
                 phase_turn, shift_count);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (phase_turn !== want.phase) begin
            $error("phase_turn mismatch: expected %0d, actual %0d", want.phase, phase_turn);
            fail_count++;
          end
          if (shift_count !== want.shift) begin
            $error("shift_count mismatch: expected %0d, actual %0d", want.shift, shift_count);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(predict_delay(period_ticks, sine_sum, cosine_sum,
                                                 manual_shift, auto_on));
      if (cfg_wr_en) auto_on <= cfg_wr_data;
    end
    pending_count = expected_results.size();
  end

endmodule

// ===== tb/tb_phase_to_delay_count_top.sv =====
`timescale 1ns / 100ps
// Testbench top for phase_to_delay_count_top: drives measurements, mode writes and output stalls.
// Depends on ptdc_pkg, the block and phase_to_delay_count_checker.
module tb_phase_to_delay_count_top;
  import ptdc_pkg::*;

  localparam int PHASE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int PERIOD_BITS   = 24;
  localparam int LATENCY       = CORDIC_STAGES + 3;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 300;

  localparam logic [FIELD_W-1:0]      PERIOD_MAX = '1;
  localparam logic signed [SUM_W-1:0] SUM_MAX    = 32'sh7fff_ffff;
  localparam logic signed [SUM_W-1:0] SUM_MIN    = 32'sh8000_0000;
  localparam logic signed [SUM_W-1:0] SUM_ZERO   = -SUM_OFFSET;

  typedef enum logic {
    MODE_MANUAL = 1'b0,
    MODE_AUTO   = 1'b1
  } shift_mode_e;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    cfg_wr_en;
  logic                    cfg_wr_data;
  logic                    in_valid;
  logic                    in_ready;
  logic [FIELD_W-1:0]      period_ticks;
  logic signed [SUM_W-1:0] sine_sum;
  logic signed [SUM_W-1:0] cosine_sum;
  logic [FIELD_W-1:0]      manual_shift;
  logic                    out_valid;
  logic                    out_ready;
  logic [PHASE_BITS:0]     phase_turn;
  logic [FIELD_W-1:0]      shift_count;

  int fail_count;
  int pending_count;
  int cycle_count = 0;

  bit tx_fast   = 1'b0;
  bit tx_burst  = 1'b0;
  bit rx_fast   = 1'b0;
  bit hold_req  = 1'b0;
  int rx_wait;
  int hold_count;
  logic rx_seen;

  phase_to_delay_count_top #(
    .PHASE_BITS   (PHASE_BITS),
    .CORDIC_STAGES(CORDIC_STAGES),
    .PERIOD_BITS  (PERIOD_BITS)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .period_ticks(period_ticks),
    .sine_sum    (sine_sum),
    .cosine_sum  (cosine_sum),
    .manual_shift(manual_shift),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .phase_turn  (phase_turn),
    .shift_count (shift_count)
  );

  phase_to_delay_count_checker #(
    .PHASE_BITS   (PHASE_BITS),
    .CORDIC_STAGES(CORDIC_STAGES),
    .PERIOD_BITS  (PERIOD_BITS)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .period_ticks (period_ticks),
    .sine_sum     (sine_sum),
    .cosine_sum   (cosine_sum),
    .manual_shift (manual_shift),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .phase_turn   (phase_turn),
    .shift_count  (shift_count),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_measurement(input logic [FIELD_W-1:0] period,
                                  input logic signed [SUM_W-1:0] s,
                                  input logic signed [SUM_W-1:0] c,
                                  input logic [FIELD_W-1:0] manual);
    int   gap;
    logic ready_seen;
    gap = (tx_fast || tx_burst) ? 0 : $urandom_range(0, 15);
    if ($urandom_range(0, 15) == 0) tx_fast = !tx_fast;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    period_ticks <= period;
    sine_sum     <= s;
    cosine_sum   <= c;
    manual_shift <= manual;
    do begin
      @(negedge clk);
      ready_seen = in_ready;
      @(posedge clk);
    end while (!ready_seen);
  endtask

  task automatic set_mode(input shift_mode_e mode);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // axis vectors, saturation, both-zero, zero period, wrap near zero angle
  task automatic run_directed();
    send_measurement(PERIOD_MAX, SUM_ZERO, SUM_ZERO, PERIOD_MAX);
    send_measurement(24'd1000, SUM_ZERO, 32'sd1000, 24'd0);
    send_measurement(24'd1000, SUM_ZERO, -32'sd1000, 24'd5);
    send_measurement(24'd12345, 32'sd1000, SUM_ZERO, 24'd77);
    send_measurement(24'd12345, -32'sd1000, SUM_ZERO, PERIOD_MAX);
    send_measurement(24'd0, 32'sd100, 32'sd100, 24'd777);
    send_measurement(24'd1, SUM_MAX, SUM_MAX, 24'd0);
    send_measurement(PERIOD_MAX, SUM_MIN, SUM_MIN, PERIOD_MAX);
    send_measurement(PERIOD_MAX, SUM_MAX, SUM_MIN, 24'h555555);
    send_measurement(24'h800000, SUM_MIN, SUM_MAX, 24'haaaaaa);
    send_measurement(24'h7fffff, -32'sd5, -32'sd100000, 24'h123456);
    send_measurement(PERIOD_MAX, -32'sd5, 32'sd100000, 24'hfedcba);
  endtask

  function automatic logic signed [SUM_W-1:0] draw_sum();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return SUM_ZERO + $signed($urandom_range(0, 16)) - 32'sd8;
      3: begin
        case ($urandom_range(0, 3))
          0: return SUM_MAX;
          1: return SUM_MIN;
          2: return SUM_MAX - 32'sd4;
          default: return SUM_ZERO;
        endcase
      end
      4: return $signed({{16{1'b0}}, 16'($urandom)}) - 32'sd32768;
      default: return $signed($urandom) >>> $urandom_range(0, 30);
    endcase
  endfunction

  task automatic run_random(input int count);
    logic [FIELD_W-1:0] period;
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] c;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0: period = '0;
        1: period = 24'd1;
        2: period = PERIOD_MAX;
        3: period = FIELD_W'($urandom_range(1, 255));
        default: period = FIELD_W'($urandom);
      endcase
      s = draw_sum();
      c = draw_sum();
      send_measurement(period, s, c, FIELD_W'($urandom));
    end
  endtask

  // receiver: random stalls per result, plus one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    do @(negedge clk); while (rst);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready  <= 1'b0;
        hold_count = 0;
        while (hold_count < HOLD_CYCLES) begin
          @(posedge clk);
          hold_count++;
        end
        hold_req = 1'b0;
      end
      rx_wait = rx_fast ? 0 : $urandom_range(0, 15);
      if ($urandom_range(0, 15) == 0) rx_fast = !rx_fast;
      if (rx_wait > 0) begin
        out_ready <= 1'b0;
        repeat (rx_wait) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        rx_seen = out_valid;
        @(posedge clk);
      end while (!rx_seen);
    end
  end

  initial begin
    rst          <= 1'b1;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= MODE_AUTO;
    in_valid     <= 1'b0;
    period_ticks <= '0;
    sine_sum     <= '0;
    cosine_sum   <= '0;
    manual_shift <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    set_mode(MODE_MANUAL);
    run_directed();

    set_mode(MODE_AUTO);
    run_random(200);

    set_mode(MODE_MANUAL);
    run_random(150);

    set_mode(MODE_AUTO);
    run_random(50);
    hold_req = 1'b1;
    tx_burst = 1'b1;
    run_random(60);
    tx_burst = 1'b0;
    run_random(90);

    set_mode(MODE_MANUAL);
    run_random(100);

    set_mode(MODE_AUTO);
    run_random(150);

    in_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    repeat (LATENCY + 5) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
